[src/fcir_pkg.sv]
// ----------------------------------------------------------------------------
// fcir_pkg: shared definitions for the frame capture block
// Default sizes, field widths and the result record handed to the output stage.
// ----------------------------------------------------------------------------
package fcir_pkg;

    localparam int FRAME_SIZE_DEF  = 256;
    localparam int CHANNELS_DEF    = 2;
    localparam int IDLE_GROUPS_DEF = 5;

    localparam int SAMPLE_W = 15;
    localparam int INDEX_W  = 8;

    // 0.01 of full scale (32768), rounded
    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 15'd328;

    typedef logic [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic                 frame_done;
        logic                 idle_restart;
        sample_t              sample_out;
        logic [INDEX_W-1:0]   write_index;
        logic                 stored;
    } result_t;

endpackage

[src/fcir_cell.sv]
// ----------------------------------------------------------------------------
// fcir_cell: one history cell
// Holds one sample, hands it to the next cell on every write and flags
// whether the incoming value stays within the threshold of its channel head.
// ----------------------------------------------------------------------------
module fcir_cell (
    input  logic              aclk,
    input  logic              shift_en,
    input  fcir_pkg::sample_t d_in,
    input  fcir_pkg::sample_t ref_in,
    input  fcir_pkg::sample_t threshold,
    output fcir_pkg::sample_t q,
    output logic              quiet
);

    fcir_pkg::sample_t q_reg;
    fcir_pkg::sample_t diff;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            q_reg <= d_in;
        end
    end

    // absolute difference of the values this cell and its head take on the write
    always_comb begin
        diff = (d_in > ref_in) ? (d_in - ref_in) : (ref_in - d_in);
    end

    assign quiet = (diff <= threshold);
    assign q     = q_reg;

endmodule

[src/fcir_skid.sv]
// ----------------------------------------------------------------------------
// fcir_skid: output register with skid stage
// Takes a result while the output holds a stalled one; drains skid first.
// ----------------------------------------------------------------------------
module fcir_skid (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  fcir_pkg::result_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output fcir_pkg::result_t  out_data
);

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    fcir_pkg::result_t out_reg, out_next;
    fcir_pkg::result_t skid_reg, skid_next;

    assign in_ready = !skid_valid_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (out_valid_reg && !out_ready) begin
            // hold output, park a new result in skid
            if (in_valid && !skid_valid_reg) begin
                skid_valid_next = 1'b1;
                skid_next       = in_data;
            end
        end else if (skid_valid_reg) begin
            out_valid_next  = 1'b1;
            out_next        = skid_reg;
            skid_valid_next = 1'b0;
        end else begin
            out_valid_next = in_valid;
            out_next       = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

[src/frame_capture_idle_restart.sv]
// ----------------------------------------------------------------------------
// frame_capture_idle_restart: multiplexed sample frame capture with idle restart
// Syncs on the last mux channel, writes samples to successive frame positions
// and restarts the frame when every channel has stayed still for a window.
// ----------------------------------------------------------------------------
//
//  channel  | direction | ports                              | payload
//  ---------+-----------+------------------------------------+---------------------
//  s_       | in        | s_tvalid s_tready s_tdata s_tuser  | sample, channel
//  m_       | out       | m_tvalid m_tready m_tdata m_tuser  | index, sample, flags
//           |           | m_tlast                            | frame_done
//  cfg_     | in        | cfg_we cfg_wdata                   | idle_threshold
//
//  One transfer per cycle while s_tready is high: each item is decided in the
//  cycle it is accepted, the history chain comparing all cells in parallel; the
//  result is registered in the output register, or in the skid stage if stalled.
//  Reset (aresetn low, synchronous) enters syncing at position 0 and loads
//  the threshold with 328; history cells are not cleared.
//  A stalled output keeps one more result in the skid stage; s_tready drops
//  only once that stage is full.
// ----------------------------------------------------------------------------
module frame_capture_idle_restart #(
    parameter int FRAME_SIZE  = fcir_pkg::FRAME_SIZE_DEF,
    parameter int CHANNELS    = fcir_pkg::CHANNELS_DEF,
    parameter int IDLE_GROUPS = fcir_pkg::IDLE_GROUPS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [14:0] sample, [15] zero fill
    input  logic [0:0]  s_tuser,   // [0] channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] write_index, [22:8] sample_out, [23] zero
    output logic [1:0]  m_tuser,   // [0] stored, [1] idle_restart
    output logic        m_tlast,   // frame_done
    input  logic        cfg_we,
    input  logic [14:0] cfg_wdata  // idle_threshold
);

    localparam int HIST_DEPTH  = CHANNELS * IDLE_GROUPS;
    localparam int INFER_LIMIT = (9 * FRAME_SIZE) / 10;
    localparam int POS_MAX     = (FRAME_SIZE > HIST_DEPTH) ? FRAME_SIZE : HIST_DEPTH;
    localparam int POS_W       = $clog2(POS_MAX + 1);
    localparam int GRP_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    // sync channel must fit the one-bit channel field
    localparam bit   SYNC_REACH = (CHANNELS <= 2);
    localparam logic SYNC_CODE  = 1'(CHANNELS - 1);

    logic                 syncing_reg, syncing_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [GRP_W-1:0]     grp_reg, grp_next;
    fcir_pkg::sample_t    thr_reg;

    logic                 accept;
    logic                 write_en;
    logic [POS_W-1:0]     pos_inc;
    logic                 grp_wrap;
    logic                 frame_full;
    logic                 check_win;
    logic                 idle;
    logic                 fwd_ready;
    fcir_pkg::sample_t    sample_in;
    fcir_pkg::result_t    result;
    fcir_pkg::result_t    out_data;

    fcir_pkg::sample_t    cell_din [HIST_DEPTH];
    fcir_pkg::sample_t    cell_q   [HIST_DEPTH];
    logic [HIST_DEPTH-1:0] cell_quiet;

    assign sample_in = s_tdata[14:0];
    assign s_tready  = fwd_ready;
    assign accept    = s_tvalid && fwd_ready;
    assign write_en  = accept && !syncing_reg;

    // Threshold register: to be written while the block is idle; the block itself does not enforce this
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= fcir_pkg::THRESHOLD_RESET;
        end else if (cfg_we) begin
            thr_reg <= cfg_wdata;
        end
    end

    // History chain: newest sample enters cell 0, each cell passes on its value.
    // Every cell compares its incoming value with the incoming value of the
    // head cell of its channel.
    for (genvar k = 0; k < HIST_DEPTH; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign cell_din[k] = sample_in;
        end else begin : g_link
            assign cell_din[k] = cell_q[k-1];
        end

        fcir_cell u_cell (
            .aclk      (aclk),
            .shift_en  (write_en),
            .d_in      (cell_din[k]),
            .ref_in    (cell_din[k % CHANNELS]),
            .threshold (thr_reg),
            .q         (cell_q[k]),
            .quiet     (cell_quiet[k])
        );
    end

    assign idle = &cell_quiet;

    // Position bookkeeping; grp_reg tracks position modulo CHANNELS
    assign pos_inc    = pos_reg + POS_W'(1);
    assign grp_wrap   = (grp_reg == GRP_W'(CHANNELS - 1));
    assign frame_full = (pos_inc >= POS_W'(FRAME_SIZE));
    assign check_win  = grp_wrap && (pos_inc >= POS_W'(HIST_DEPTH))
                        && (pos_inc < POS_W'(INFER_LIMIT));

    always_comb begin
        syncing_next = syncing_reg;
        pos_next     = pos_reg;
        grp_next     = grp_reg;
        result       = '0;
        if (accept) begin
            if (syncing_reg) begin
                // drop items until the last channel shows up
                if (SYNC_REACH && (s_tuser[0] == SYNC_CODE)) begin
                    syncing_next = 1'b0;
                end
            end else begin
                result.stored      = 1'b1;
                result.write_index = fcir_pkg::INDEX_W'(pos_reg);
                result.sample_out  = sample_in;
                pos_next           = pos_inc;
                grp_next           = grp_wrap ? '0 : grp_reg + GRP_W'(1);
                if (frame_full) begin
                    result.frame_done = 1'b1;
                    pos_next          = '0;
                    grp_next          = '0;
                    syncing_next      = 1'b1;
                end else if (check_win && idle) begin
                    result.idle_restart = 1'b1;
                    pos_next            = '0;
                    grp_next            = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            syncing_reg <= 1'b1;
            pos_reg     <= '0;
            grp_reg     <= '0;
        end else begin
            syncing_reg <= syncing_next;
            pos_reg     <= pos_next;
            grp_reg     <= grp_next;
        end
    end

    // Output register with skid stage
    fcir_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept),
        .in_ready  (fwd_ready),
        .in_data   (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {1'b0, out_data.sample_out, out_data.write_index};
    assign m_tuser = {out_data.idle_restart, out_data.stored};
    assign m_tlast = out_data.frame_done;

    // ------------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------------
    a_sync_pos_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        syncing_reg |-> (pos_reg == '0) && (grp_reg == '0))
        else $error("position not cleared while syncing");

    a_pos_in_frame : assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg < POS_W'(FRAME_SIZE))
        else $error("frame position out of range");

    a_flags_exclusive : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tlast || m_tuser[1]) |-> m_tuser[0] && !(m_tlast && m_tuser[1]))
        else $error("restart/done flags on a non-stored or doubly flagged result");

    a_stall_only_full : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with output empty");

    a_done_resyncs : assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !syncing_reg && frame_full |=> syncing_reg)
        else $error("full frame did not return to syncing");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for frame_capture_idle_restart
// Sends sync, capture, idle-restart and full-frame sequences into the input
// stream. Gaps on the input side and stalls on the output side are random.
// The bench keeps its own copy of the capture state and threshold, predicts
// each result and compares every output transfer field by field.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int      CH_COUNT     = fcir_pkg::CHANNELS_DEF;
    localparam int      HIST_DEPTH   = fcir_pkg::CHANNELS_DEF * fcir_pkg::IDLE_GROUPS_DEF;
    localparam int      CHECK_LIMIT  = (9 * fcir_pkg::FRAME_SIZE_DEF) / 10;
    localparam int      SAMPLE_MAX   = 32760;
    localparam fcir_pkg::sample_t THRESH_MAX = 15'h7FFF;
    localparam logic    SYNC_CH      = logic'(CH_COUNT - 1);
    localparam int      CYCLE_LIMIT  = 200000;
    localparam int      REPORT_CAP   = 40;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // [14:0] sample, [15] zero fill
    logic [0:0]  s_tuser;    // [0] channel
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;    // [7:0] write_index, [22:8] sample_out, [23] zero fill
    logic [1:0]  m_tuser;    // [0] stored, [1] idle_restart
    logic        m_tlast;    // frame_done
    logic        cfg_we;
    logic [14:0] cfg_wdata;  // idle_threshold

    // Capture state as the block should hold it
    bit                cap_syncing   = 1'b1;
    int unsigned       cap_pos       = 0;
    fcir_pkg::sample_t cap_history[HIST_DEPTH];
    fcir_pkg::sample_t cap_threshold = fcir_pkg::THRESHOLD_RESET;

    // Results still owed by the block, oldest first
    fcir_pkg::result_t expected_captures[$];

    // Run control shared between the stimulus and sink processes
    bit          offering       = 1'b0;
    bit          src_gaps_on    = 1'b1;
    bit          sink_stalls_on = 1'b1;
    bit          long_hold_req  = 1'b0;
    int          long_hold_len  = 0;

    int          mismatch_count  = 0;
    int          cycle_count     = 0;
    int          items_sent      = 0;
    int          results_seen    = 0;
    int          writes_seen     = 0;
    int          restarts_seen   = 0;
    int          frames_seen     = 0;
    int          input_stalls    = 0;
    int          thresholds_used = 0;

    frame_capture_idle_restart dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Hard stop: no correct run comes anywhere near this many cycles
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, expected_captures.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Prediction: advance the local capture state by one accepted transfer
    // and return the result the block must emit for it.
    // ------------------------------------------------------------------------
    function automatic fcir_pkg::result_t predict_capture(logic ch, fcir_pkg::sample_t smp);
        fcir_pkg::result_t r;
        int unsigned       pos;
        int                k;
        int                c;
        int                g;
        int                d;
        bit                still;
        r = '0;
        // While syncing, only the last mux channel ends the wait; nothing is stored
        if (cap_syncing) begin
            if (ch == SYNC_CH) begin
                cap_syncing = 1'b0;
            end
            return r;
        end
        pos = cap_pos;
        // Shift the history, newest sample in slot 0
        for (k = HIST_DEPTH - 1; k > 0; k--) begin
            cap_history[k] = cap_history[k - 1];
        end
        cap_history[0] = smp;
        cap_pos = pos + 1;
        if (cap_pos >= fcir_pkg::FRAME_SIZE_DEF) begin
            // Frame full: flag it and go back to waiting for the sync channel
            r.frame_done = 1'b1;
            cap_pos      = 0;
            cap_syncing  = 1'b1;
        end else if ((cap_pos % CH_COUNT) == 0 && cap_pos >= HIST_DEPTH &&
                     cap_pos < CHECK_LIMIT) begin
            // Group boundary inside the check window: every channel's latest
            // sample must sit within the threshold of its older group samples
            still = 1'b1;
            for (c = 0; c < CH_COUNT; c++) begin
                for (g = 1; g < fcir_pkg::IDLE_GROUPS_DEF; g++) begin
                    d = int'(cap_history[c + g * CH_COUNT]) - int'(cap_history[c]);
                    if (d < 0) begin
                        d = -d;
                    end
                    if (d > int'(cap_threshold)) begin
                        still = 1'b0;
                    end
                end
            end
            if (still) begin
                r.idle_restart = 1'b1;
                cap_pos        = 0;
            end
        end
        r.stored      = 1'b1;
        r.write_index = pos[fcir_pkg::INDEX_W-1:0];
        r.sample_out  = smp;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic fcir_pkg::sample_t random_sample();
        return fcir_pkg::sample_t'($urandom_range(0, SAMPLE_MAX));
    endfunction

    // Pick a level that leaves room for a full threshold swing above it
    function automatic fcir_pkg::sample_t pick_base();
        int span;
        span = (int'(cap_threshold) > SAMPLE_MAX) ? SAMPLE_MAX : int'(cap_threshold);
        return fcir_pkg::sample_t'($urandom_range(0, SAMPLE_MAX - span));
    endfunction

    // A sample within the threshold of the base, so any two of them count as still
    function automatic fcir_pkg::sample_t still_sample(fcir_pkg::sample_t base);
        int span;
        span = SAMPLE_MAX - int'(base);
        if (span > int'(cap_threshold)) begin
            span = int'(cap_threshold);
        end
        return fcir_pkg::sample_t'(int'(base) + int'($urandom_range(0, span)));
    endfunction

    // The channel the mux would really show, now and then a wrong one
    function automatic logic capture_channel();
        return logic'(cap_pos % CH_COUNT) ^ ($urandom_range(0, 9) == 0);
    endfunction

    // Offer one item and hold it until the block takes it; predict on acceptance
    task automatic send_item(input logic ch, input fcir_pkg::sample_t smp);
        int gap;
        if (src_gaps_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 17);
            if (offering) begin
                s_tvalid <= 1'b0;
                offering = 1'b0;
            end
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, smp};
        s_tuser  <= ch;
        offering = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_captures.push_back(predict_capture(ch, smp));
        items_sent++;
    endtask

    // Drop valid and wait until every owed result has been taken
    task automatic settle_outputs();
        if (offering) begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end
        while (expected_captures.size() != 0) @(posedge aclk);
    endtask

    // Threshold writes only happen with the block drained
    task automatic set_threshold(input fcir_pkg::sample_t value);
        settle_outputs();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cap_threshold = value;
        thresholds_used++;
    endtask

    // Noise on the other channel, then the sync channel to start a frame
    task automatic resync();
        int noise;
        noise = $urandom_range(0, 2);
        repeat (noise) send_item(~SYNC_CH, random_sample());
        send_item(SYNC_CH, random_sample());
    endtask

    // Capture run: each channel group is either still (near one level) or moving.
    // Sync transfers are not counted toward the run length.
    task automatic run_capture_mix(input int count, input int still_pct);
        fcir_pkg::sample_t base;
        bit                quiet;
        int                n;
        n     = 0;
        quiet = 1'b0;
        base  = pick_base();
        while (n < count) begin
            if (cap_syncing) begin
                resync();
            end
            if ((cap_pos % CH_COUNT) == 0) begin
                quiet = ($urandom_range(0, 99) < still_pct);
                if ($urandom_range(0, 7) == 0) begin
                    base = pick_base();
                end
            end
            send_item(capture_channel(), quiet ? still_sample(base) : random_sample());
            n++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Sync handling, field extremes and the idle decision right at the
    // threshold, all with the threshold left at its reset value
    task automatic test_directed_capture();
        int g;
        // Ignored while syncing: wrong channel, both sample extremes
        send_item(1'b0, fcir_pkg::sample_t'(SAMPLE_MAX));
        send_item(1'b0, 15'd0);
        // Sync item itself is not stored
        send_item(SYNC_CH, 15'd12345);
        // Differences of exactly the threshold still count as no movement;
        // channel tied to 0 to show the position alone decides placement
        for (g = 0; g < fcir_pkg::IDLE_GROUPS_DEF; g++) begin
            send_item(1'b0, (g % 2) ? 15'd1328 : 15'd1000);
            send_item(1'b0, (g % 2) ? 15'd32432 : fcir_pkg::sample_t'(SAMPLE_MAX));
        end
        // One step past the threshold keeps the frame running
        for (g = 0; g < fcir_pkg::IDLE_GROUPS_DEF; g++) begin
            send_item(1'b1, (g == 1) ? 15'd1329 : 15'd1000);
            send_item(1'b1, fcir_pkg::sample_t'(SAMPLE_MAX));
        end
        send_item(1'b0, 15'd1000);
        send_item(1'b1, fcir_pkg::sample_t'(SAMPLE_MAX));
    endtask

    // Zero threshold needs identical samples; the largest one makes anything still
    task automatic test_threshold_extremes();
        set_threshold(15'd0);
        run_capture_mix(40, 80);
        set_threshold(THRESH_MAX);
        run_capture_mix(40, 0);
    endtask

    // Moving samples all the way through a frame: last index, done, resync
    task automatic test_full_frame();
        set_threshold(15'd50);
        run_capture_mix(fcir_pkg::FRAME_SIZE_DEF + 6, 0);
    endtask

    // Hold the output long enough to fill the block and stall its input,
    // then pause the sender until everything has come out
    task automatic test_output_backpressure();
        set_threshold(fcir_pkg::THRESHOLD_RESET);
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        long_hold_len  = 120;
        long_hold_req  = 1'b1;
        run_capture_mix(24, 50);
        settle_outputs();
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    // Random thresholds, mixes of still and moving groups, idling toggled per phase
    task automatic test_random_mix();
        int phase;
        for (phase = 0; phase < 2; phase++) begin
            set_threshold(fcir_pkg::sample_t'($urandom_range(0, 4000)));
            src_gaps_on    = ($urandom_range(0, 3) != 0);
            sink_stalls_on = ($urandom_range(0, 3) != 0);
            run_capture_mix($urandom_range(30, 50), $urandom_range(20, 90));
        end
    endtask

    // Last stretch at full rate on both sides
    task automatic test_back_to_back();
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        set_threshold(fcir_pkg::THRESHOLD_RESET);
        run_capture_mix(40, 60);
    endtask

    // ------------------------------------------------------------------------
    // Output sink: random stall bursts, or one long counted hold on request
    // ------------------------------------------------------------------------
    initial begin : sink_side
        int hold;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                m_tready <= 1'b0;
                hold = 0;
                while (hold < long_hold_len) begin
                    @(posedge aclk);
                    hold++;
                end
                m_tready <= 1'b1;
                long_hold_req = 1'b0;
            end else if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Checker: every output transfer against the oldest owed result
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string field, input int got, input int want);
        if (mismatch_count < REPORT_CAP) begin
            $display("mismatch at output transfer %0d, %s: got %0d, want %0d",
                     results_seen, field, got, want);
        end
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : result_check
        fcir_pkg::result_t seen;
        fcir_pkg::result_t want;
        if (aresetn && s_tvalid && !s_tready) begin
            input_stalls++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            seen.stored       = m_tuser[0];
            seen.idle_restart = m_tuser[1];
            seen.write_index  = m_tdata[7:0];
            seen.sample_out   = m_tdata[22:8];
            seen.frame_done   = m_tlast;
            if (expected_captures.size() == 0) begin
                report_mismatch("result with nothing pending", 1, 0);
            end else begin
                want = expected_captures.pop_front();
                if (seen.stored !== want.stored)
                    report_mismatch("stored", seen.stored, want.stored);
                if (seen.write_index !== want.write_index)
                    report_mismatch("write_index", seen.write_index, want.write_index);
                if (seen.sample_out !== want.sample_out)
                    report_mismatch("sample_out", seen.sample_out, want.sample_out);
                if (seen.idle_restart !== want.idle_restart)
                    report_mismatch("idle_restart", seen.idle_restart, want.idle_restart);
                if (seen.frame_done !== want.frame_done)
                    report_mismatch("frame_done", seen.frame_done, want.frame_done);
                writes_seen   += want.stored;
                restarts_seen += want.idle_restart;
                frames_seen   += want.frame_done;
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        // Known values on every input from time zero, with reset held low at the start
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        foreach (cap_history[i]) cap_history[i] = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_capture();
        test_threshold_extremes();
        test_full_frame();
        test_output_backpressure();
        test_random_mix();
        test_back_to_back();

        // Drain, then let the output stage show anything stray
        settle_outputs();
        repeat (4) @(posedge aclk);

        $display("Run covered %0d input transfers, %0d frame writes, %0d idle restarts,",
                 items_sent, writes_seen, restarts_seen);
        $display("%0d full frames, %0d threshold writes, %0d cycles of input stalled.",
                 frames_seen, thresholds_used, input_stalls);
        if (mismatch_count == 0 && expected_captures.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[files.f]
src/fcir_pkg.sv
src/fcir_cell.sv
src/fcir_skid.sv
src/frame_capture_idle_restart.sv
verif/tb_top.sv
